[hw/rtl/wscm_pkg.sv]
// wscm_pkg: shared types, widths and constants of the water shell cutoff marker
// depends on nothing; imported by the top module and wscm_dist
package wscm_pkg;

  // fixed field widths
  localparam int CRD_W   = 24;
  localparam int SHELL_W = 3;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int CUT_W   = 50;
  localparam int BOX_W   = 23;
  localparam int CFG_W   = CUT_W;
  localparam int CFG_IDX_W = 3;

  // default batch depth
  localparam int MAX_SITES_DEF = 64;

  // distance datapath widths
  localparam int DIFF_W = CRD_W + 1;
  localparam int FOLD_W = CRD_W + 2;
  localparam int MAG_W  = CRD_W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIODIC = 3'd4;

  // register reset values
  localparam logic [CUT_W-1:0] CUTOFF_RST = CUT_W'(150994944);
  localparam logic [BOX_W-1:0] BOX_RST    = BOX_W'(131072);

  // shell codes
  localparam logic [SHELL_W-1:0] SHELL_WATER   = 3'd1;
  localparam logic [SHELL_W-1:0] SHELL_OUTSIDE = 3'd3;
  localparam logic [SHELL_W-1:0] SHELL_INSIDE  = 3'd7;
  localparam logic [SHELL_W-1:0] SHELL_DRAW    = 3'd4;

  typedef struct packed {
    logic signed [CRD_W-1:0] pos_x;
    logic signed [CRD_W-1:0] pos_y;
    logic signed [CRD_W-1:0] pos_z;
    logic [SHELL_W-1:0]      shell_in;
    logic                    last_site;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   site_index;
    logic [SHELL_W-1:0] shell_out;
    logic [CNT_W-1:0]   shell_count;
    logic               last_result;
  } out_item_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] z;
  } coord_t;

  // control from sequencer into the distance pipeline
  typedef struct packed {
    logic valid;
    logic nonwater;
  } dist_ctl_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_RD_I,
    S_LATCH_I,
    S_SCAN,
    S_DRAIN,
    S_WRITE_I,
    S_EM_RD,
    S_EM_LOAD,
    S_EM_HOLD
  } state_t;

endpackage

[hw/rtl/water_shell_cutoff_marker_top.sv]
// water_shell_cutoff_marker_top: loads a batch of sites, marks water oxygens in shell
// sites load while in_ready is high; after the last site, each water oxygen is scanned
// against all loaded sites through the single shared distance pipeline, then results leave
// one result per site, each held until out_ready is high; no new batch loads meanwhile
// reset: synchronous, clears control state, counters and configuration registers; no clearing pass on ram
// depends on wscm_pkg, wscm_ram, wscm_dist
module water_shell_cutoff_marker_top
  import wscm_pkg::*;
#(
  parameter int MAX_SITES = MAX_SITES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = $clog2(MAX_SITES);
  localparam int CW = $clog2(MAX_SITES + 1);

  // configuration
  logic [CUT_W-1:0] cutoff_sq;
  logic [BOX_W-1:0] box_x, box_y, box_z;
  logic             periodic;

  state_t state, state_next;

  logic [CW-1:0]      site_count;
  logic [AW-1:0]      i_idx, j_idx, k_idx;
  logic [CNT_W-1:0]   hits;
  logic               hit;
  logic               rv;
  coord_t             coord_i;
  logic [SHELL_W-1:0] shell_i;
  logic [SHELL_W-1:0] shell_new;

  // ram ports
  logic               c_we;
  logic [AW-1:0]      c_waddr;
  coord_t             c_wdata, c_rdata;
  logic               s_we;
  logic [AW-1:0]      s_waddr;
  logic [SHELL_W-1:0] s_wdata, s_rdata;
  logic [AW-1:0]      raddr;

  logic      accept, store, cut_zero, i_last, j_last, k_last;
  logic      dist_hit, dist_busy;
  dist_ctl_t dctl;

  assign accept   = in_valid & in_ready;
  assign store    = accept & (site_count < CW'(MAX_SITES));
  assign cut_zero = (cutoff_sq == '0);
  assign i_last   = (CW'(i_idx) + 1'b1 == site_count);
  assign j_last   = (CW'(j_idx) + 1'b1 == site_count);
  assign k_last   = (CW'(k_idx) + 1'b1 == site_count);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff_sq <= CUTOFF_RST;
      box_x     <= BOX_RST;
      box_y     <= BOX_RST;
      box_z     <= BOX_RST;
      periodic  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CUTOFF:   cutoff_sq <= cfg_data[CUT_W-1:0];
        REG_BOX_X:    box_x     <= cfg_data[BOX_W-1:0];
        REG_BOX_Y:    box_y     <= cfg_data[BOX_W-1:0];
        REG_BOX_Z:    box_z     <= cfg_data[BOX_W-1:0];
        REG_PERIODIC: periodic  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD:    if (accept && in_item.last_site) state_next = S_RD_I;
      S_RD_I:    state_next = S_LATCH_I;
      S_LATCH_I: begin
        if (!cut_zero && s_rdata[0] && s_rdata[1]) state_next = S_SCAN;
        else state_next = S_WRITE_I;
      end
      S_SCAN:    if (j_last) state_next = S_DRAIN;
      S_DRAIN:   if (!rv && !dist_busy) state_next = S_WRITE_I;
      S_WRITE_I: state_next = i_last ? S_EM_RD : S_RD_I;
      S_EM_RD:   state_next = S_EM_LOAD;
      S_EM_LOAD: state_next = S_EM_HOLD;
      S_EM_HOLD: begin
        if (out_ready) state_next = k_last ? S_LOAD : S_EM_RD;
      end
      default:   state_next = S_LOAD;
    endcase
  end

  // new shell bits for site i
  always_comb begin
    if (cut_zero) begin
      shell_new = shell_i | SHELL_DRAW;
    end else if (!shell_i[0]) begin
      shell_new = shell_i;
    end else if (!shell_i[1]) begin
      shell_new = SHELL_WATER;
    end else begin
      shell_new = hit ? SHELL_INSIDE : SHELL_OUTSIDE;
    end
  end

  // ram control outputs
  always_comb begin
    in_ready = 1'b0;
    c_we     = 1'b0;
    s_we     = 1'b0;
    s_waddr  = site_count[AW-1:0];
    s_wdata  = in_item.shell_in;
    raddr    = i_idx;
    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        c_we     = store;
        s_we     = store;
      end
      S_SCAN:    raddr = j_idx;
      S_WRITE_I: begin
        s_we    = 1'b1;
        s_waddr = i_idx;
        s_wdata = shell_new;
      end
      S_EM_RD:   raddr = k_idx;
      default: ;
    endcase
  end

  assign c_waddr = site_count[AW-1:0];
  assign c_wdata = '{x: in_item.pos_x, y: in_item.pos_y, z: in_item.pos_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // batch counters and marking
  always_ff @(posedge clk) begin
    if (rst) begin
      site_count <= '0;
      hits       <= '0;
      i_idx      <= '0;
      j_idx      <= '0;
      k_idx      <= '0;
      hit        <= 1'b0;
      rv         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rv <= (state == S_SCAN);
      if (dist_hit) hit <= 1'b1;
      unique case (state)
        S_LOAD: begin
          if (store) site_count <= site_count + 1'b1;
          i_idx <= '0;
        end
        S_LATCH_I: begin
          hit   <= 1'b0;
          j_idx <= '0;
        end
        S_SCAN: j_idx <= j_idx + 1'b1;
        S_WRITE_I: begin
          if (!cut_zero && shell_i[0] && shell_i[1] && hit) hits <= hits + 1'b1;
          i_idx <= i_idx + 1'b1;
          k_idx <= '0;
        end
        S_EM_LOAD: out_valid <= 1'b1;
        S_EM_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            k_idx     <= k_idx + 1'b1;
            if (k_last) begin
              site_count <= '0;
              hits       <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // site i operands and the result register
  always_ff @(posedge clk) begin
    if (state == S_LATCH_I) begin
      coord_i <= c_rdata;
      shell_i <= s_rdata;
    end
    if (state == S_EM_LOAD) begin
      out_item.site_index  <= IDX_W'(k_idx);
      out_item.shell_out   <= s_rdata;
      out_item.shell_count <= k_last ? hits : '0;
      out_item.last_result <= k_last;
    end
  end

  assign dctl = '{valid: rv, nonwater: ~s_rdata[0]};

  wscm_ram #(.WIDTH($bits(coord_t)), .DEPTH(MAX_SITES)) u_coord_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (raddr),
    .rdata (c_rdata)
  );

  wscm_ram #(.WIDTH(SHELL_W), .DEPTH(MAX_SITES)) u_shell_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (raddr),
    .rdata (s_rdata)
  );

  wscm_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .ctl       (dctl),
    .pa        (coord_i),
    .pb        (c_rdata),
    .box_x     (box_x),
    .box_y     (box_y),
    .box_z     (box_z),
    .periodic  (periodic),
    .cutoff_sq (cutoff_sq),
    .hit       (dist_hit),
    .busy      (dist_busy)
  );

endmodule

[hw/rtl/wscm_ram.sv]
// wscm_ram: generic single-write, single-read ram with registered read data
// depends on nothing
module wscm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/wscm_dist.sv]
// wscm_dist: four-stage squared distance pipeline with one minimum-image fold
// depends on wscm_pkg
module wscm_dist
  import wscm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  dist_ctl_t        ctl,
  input  coord_t           pa,
  input  coord_t           pb,
  input  logic [BOX_W-1:0] box_x,
  input  logic [BOX_W-1:0] box_y,
  input  logic [BOX_W-1:0] box_z,
  input  logic             periodic,
  input  logic [CUT_W-1:0] cutoff_sq,
  output logic             hit,
  output logic             busy
);

  logic signed [CRD_W-1:0]  ca [3];
  logic signed [CRD_W-1:0]  cb [3];
  logic [BOX_W-1:0]         bl [3];
  logic signed [DIFF_W-1:0] d1 [3];
  logic signed [FOLD_W-1:0] f_next [3];
  logic signed [FOLD_W-1:0] f2 [3];
  logic [MAG_W-1:0]         m_next [3];
  logic [MAG_W-1:0]         m3 [3];
  logic [SQ_W-1:0]          q4 [3];
  logic [3:0]               v;
  logic [3:0]               nw;
  logic [SUM_W-1:0]         sum;

  assign ca[0] = pa.x;
  assign ca[1] = pa.y;
  assign ca[2] = pa.z;
  assign cb[0] = pb.x;
  assign cb[1] = pb.y;
  assign cb[2] = pb.z;
  assign bl[0] = box_x;
  assign bl[1] = box_y;
  assign bl[2] = box_z;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[2:0], ctl.valid};
    end
  end

  always_ff @(posedge clk) begin
    nw <= {nw[2:0], ctl.nonwater};
  end

  // fold toward the nearest image
  always_comb begin
    logic signed [FOLD_W-1:0] dd;
    logic signed [FOLD_W-1:0] dl;
    logic signed [FOLD_W-1:0] tw;
    for (int a = 0; a < 3; a++) begin
      dd = FOLD_W'(d1[a]);
      dl = signed'(FOLD_W'({1'b0, bl[a]}));
      tw = dd <<< 1;
      f_next[a] = dd;
      if (periodic) begin
        if (tw > dl) begin
          f_next[a] = dd - dl;
        end else if (tw < -dl) begin
          f_next[a] = dd + dl;
        end
      end
    end
  end

  // magnitude
  always_comb begin
    logic signed [FOLD_W-1:0] ng;
    for (int a = 0; a < 3; a++) begin
      ng = -f2[a];
      m_next[a] = f2[a][FOLD_W-1] ? MAG_W'(ng) : MAG_W'(f2[a]);
    end
  end

  // diff, fold, magnitude and square stages
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      d1[a] <= DIFF_W'(ca[a]) - DIFF_W'(cb[a]);
      f2[a] <= f_next[a];
      m3[a] <= m_next[a];
      q4[a] <= SQ_W'(m3[a]) * SQ_W'(m3[a]);
    end
  end

  // sum and compare
  assign sum  = SUM_W'(q4[0]) + SUM_W'(q4[1]) + SUM_W'(q4[2]);
  assign hit  = v[3] & nw[3] & (sum < SUM_W'(cutoff_sq));
  assign busy = |v;

endmodule
